>>> design/swqd_pkg.sv
// Shared types and constants for the sliding-window quantile delay block.
package swqd_pkg;

  // Field widths
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned TOTAL_W = 32;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned KEEP_W  = 7;
  localparam int unsigned OUT_W   = DATA_W + TOTAL_W;

  // Operation codes carried on tuser
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Quantile constants
  localparam logic [ALPHA_W-1:0] ALPHA_DEFAULT = 8'd5;
  localparam logic [ALPHA_W-1:0] ALPHA_LOW     = 8'd1;
  localparam logic [ALPHA_W-1:0] ALPHA_HIGH    = 8'd99;
  localparam logic [KEEP_W-1:0]  PERCENT       = 7'd100;
  localparam int unsigned        ROUND_UP      = 99;
  localparam int unsigned        MIN_SAMPLES   = 10;

  // Division by 100 as multiply and shift, exact below 43699
  localparam int unsigned        RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;
  localparam int unsigned        RECIP_SHIFT = 19;

  // Cells per group in the first stage of the read-out tree
  localparam int unsigned GROUP_SIZE = 16;

  // Register map
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned REG_LSB   = 3;
  localparam int unsigned REG_IDX_W = CFG_AW - REG_LSB;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX   = 2'd2;

  // Broadcast to every cell during a chain update
  typedef struct packed {
    logic              upd;
    logic              full;
    logic              v_ge_ve;
    logic [DATA_W-1:0] smp;
    logic [DATA_W-1:0] evict;
  } cell_ctl_t;

  // What one cell shows its neighbours
  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              gt;
  } link_t;

endpackage

>>> design/swqd_cell.sv
// One cell of the sorted sample chain: holds a value, shifts with its neighbours.
module swqd_cell (
  input  logic                 clk_i,
  input  swqd_pkg::cell_ctl_t  ctl_i,
  input  logic                 valid_i,
  input  swqd_pkg::link_t      prev_i,
  input  swqd_pkg::link_t      next_i,
  output swqd_pkg::link_t      link_o
);
  import swqd_pkg::*;

  logic [DATA_W-1:0] val_q, val_d;
  logic              gt_v, le_e, ge_e;

  // Compare own word against the new sample and the evicted sample
  assign gt_v = !valid_i || (val_q > ctl_i.smp);
  assign le_e = (val_q <= ctl_i.evict);
  assign ge_e = (val_q >= ctl_i.evict);

  // Work out the next word from the cells either side
  always_comb begin
    val_d = val_q;
    if (ctl_i.full && ctl_i.v_ge_ve) begin
      // close the gap upwards: take from the next cell, or the new sample
      if (ge_e && !gt_v) begin
        val_d = next_i.gt ? ctl_i.smp : next_i.val;
      end
    end else if (gt_v && (!ctl_i.full || le_e)) begin
      // open a gap: take from the previous cell, or the new sample
      val_d = prev_i.gt ? prev_i.val : ctl_i.smp;
    end
  end

  // Hold the word between updates
  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= val_d;
    end
  end

  assign link_o.val = val_q;
  assign link_o.gt  = gt_v;

endmodule

>>> design/swqd_select.sv
// Two-stage read-out: picks the cell at a given rank through a registered OR tree.
module swqd_select #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  logic [$clog2(WINDOW)-1:0]            rank_i,
  input  logic [WINDOW-1:0][swqd_pkg::DATA_W-1:0] cells_i,
  output logic [swqd_pkg::DATA_W-1:0]          pick_o
);
  import swqd_pkg::*;

  localparam int unsigned IDXW   = $clog2(WINDOW);
  localparam int unsigned NGROUP = (WINDOW + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [DATA_W-1:0] group_q [NGROUP];

  // First stage: one-hot select within each group, registered
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    logic [GROUP_SIZE-1:0][DATA_W-1:0] term;
    logic [DATA_W-1:0]                 or_d;

    for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_term
      localparam int unsigned IDX = g * GROUP_SIZE + j;
      if (IDX < WINDOW) begin : g_live
        assign term[j] = (rank_i == IDXW'(IDX)) ? cells_i[IDX] : '0;
      end else begin : g_pad
        assign term[j] = '0;
      end
    end

    always_comb begin
      or_d = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        or_d = or_d | term[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (load_i) begin
        group_q[g] <= or_d;
      end
    end
  end

  // Second stage: merge the group results
  always_comb begin
    pick_o = '0;
    for (int g = 0; g < NGROUP; g++) begin
      pick_o = pick_o | group_q[g];
    end
  end

endmodule

>>> design/sliding_window_quantile_delay.sv
// Top level of the sliding-window quantile delay block.
//
// Usage: the slave stream takes one word per item; tuser carries the opcode
// (record or query) and tdata the 64-bit latency sample. A record stores the
// sample into the window and produces nothing; a query returns one word on
// the master stream: tdata[63:0] the clamped quantile delay, tdata[95:64]
// the saturating count of recorded samples.
// Operation: the window lives in a row of WINDOW sorted cells. A record
// reads the ring for the sample being displaced, then makes one shift of
// the whole chain. A query passes registered steps to the output register:
// rank product, rank divide by 100, group select, merge and lower clamp, upper
// clamp. One item is in work at a time; s_axis_tready is high when idle.
// The APB port sets alpha_percent, min_delay and max_delay at byte
// addresses 0, 8 and 16; write it only while the block is idle.
// Reset empties the window, clears the counts and loads register defaults;
// no clearing pass is needed. When the receiver stalls, the result word
// holds and further items are still taken; a second query then waits in
// its last step until the output register is free.
module sliding_window_quantile_delay #(
  parameter int unsigned WINDOW = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [swqd_pkg::DATA_W-1:0]   s_axis_tdata,  // [63:0] latency
  input  logic                          s_axis_tuser,  // [0] opcode
  // master stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [swqd_pkg::OUT_W-1:0]    m_axis_tdata,  // [63:0] delay, [95:64] observations
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swqd_pkg::CFG_AW-1:0]   paddr,
  input  logic [swqd_pkg::CFG_DW-1:0]   pwdata,
  output logic [swqd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import swqd_pkg::*;

  localparam int unsigned IDXW   = $clog2(WINDOW);
  localparam int unsigned CNTW   = $clog2(WINDOW + 1);
  localparam int unsigned NP_W   = CNTW + 1;
  localparam int unsigned NUM_W  = NP_W + KEEP_W;
  localparam int unsigned SUM_W  = NUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned QW     = PROD_W - RECIP_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REC,
    S_RANK,
    S_GATHER,
    S_FINAL,
    S_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ALPHA_W-1:0] alpha_q;
  logic [DATA_W-1:0]  min_q, max_q;

  // window bookkeeping
  logic [IDXW-1:0]    slot_q;
  logic [CNTW-1:0]    held_q;
  logic [TOTAL_W-1:0] total_q;

  // sample ring and work registers
  logic [DATA_W-1:0]  ring_q [WINDOW];
  logic [DATA_W-1:0]  smp_q, evict_q, pick_q;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [IDXW-1:0]    rank_q, rank_d;

  // output register
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_delay_q;
  logic [TOTAL_W-1:0] out_obs_q;

  logic               in_acc, rec_acc, qry_acc, cfg_wr, out_free, full;
  logic [ALPHA_W-1:0] eff_alpha;
  logic [KEEP_W-1:0]  keep_pct;
  logic [DATA_W-1:0]  tree_pick, lower_d;

  cell_ctl_t                     ctl;
  link_t                         link [WINDOW];
  logic [WINDOW-1:0][DATA_W-1:0] cell_vals;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign rec_acc = in_acc && (s_axis_tuser == OP_RECORD);
  assign qry_acc = in_acc && (s_axis_tuser == OP_QUERY);
  assign cfg_wr  = psel && penable && pwrite;
  assign out_free = !out_valid_q || m_axis_tready;
  assign full    = (held_q == CNTW'(WINDOW));

  // Map alpha onto the kept percentage and form (n+1)*(100-alpha)
  always_comb begin
    eff_alpha = ((alpha_q >= ALPHA_LOW) && (alpha_q <= ALPHA_HIGH)) ? alpha_q : ALPHA_DEFAULT;
    keep_pct  = PERCENT - eff_alpha[KEEP_W-1:0];
    num_d     = (NUM_W'(held_q) + NUM_W'(1)) * NUM_W'(keep_pct);
  end

  // Divide by 100 rounding up, drop one, and keep inside the held range
  always_comb begin
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    logic [QW-1:0]     quot, rk, lim;
    sum  = SUM_W'(num_q) + SUM_W'(ROUND_UP);
    prod = PROD_W'(sum) * PROD_W'(RECIP_100);
    quot = prod[PROD_W-1:RECIP_SHIFT];
    rk   = (quot == '0) ? '0 : quot - QW'(1);
    lim  = QW'(held_q) - QW'(1);
    if (rk > lim) begin
      rk = lim;
    end
    rank_d = rk[IDXW-1:0];
  end

  // Raise to the lower clamp; too few samples answer the upper clamp
  always_comb begin
    if (held_q < CNTW'(MIN_SAMPLES)) begin
      lower_d = max_q;
    end else if (tree_pick < min_q) begin
      lower_d = min_q;
    end else begin
      lower_d = tree_pick;
    end
  end

  // Sequencer, bookkeeping, registers and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      alpha_q     <= ALPHA_DEFAULT;
      min_q       <= '0;
      max_q       <= '1;
      slot_q      <= '0;
      held_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_delay_q <= '0;
      out_obs_q   <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[CFG_AW-1:REG_LSB])
          REG_ALPHA: alpha_q <= pwdata[ALPHA_W-1:0];
          REG_MIN:   min_q   <= pwdata;
          REG_MAX:   max_q   <= pwdata;
          default: ;
        endcase
      end

      // Drop the taken result word unless the last query step refills it
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (rec_acc) begin
            state_q <= S_REC;
          end else if (qry_acc) begin
            state_q <= S_RANK;
          end
        end
        S_REC: begin
          slot_q <= (slot_q == IDXW'(WINDOW - 1)) ? '0 : slot_q + IDXW'(1);
          if (!full) begin
            held_q <= held_q + CNTW'(1);
          end
          if (total_q != '1) begin
            total_q <= total_q + TOTAL_W'(1);
          end
          state_q <= S_IDLE;
        end
        S_RANK:   state_q <= S_GATHER;
        S_GATHER: state_q <= S_FINAL;
        S_FINAL:  state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_delay_q <= (pick_q > max_q) ? max_q : pick_q;
            out_obs_q   <= total_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Write the new sample into its slot, read back the one it displaces
  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      evict_q        <= ring_q[slot_q];
      ring_q[slot_q] <= s_axis_tdata;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    if (rec_acc) begin
      smp_q <= s_axis_tdata;
    end
    if (qry_acc) begin
      num_q <= num_d;
    end
    if (state_q == S_RANK) begin
      rank_q <= rank_d;
    end
    if (state_q == S_FINAL) begin
      pick_q <= lower_d;
    end
  end

  // Broadcast to the chain
  assign ctl.upd     = (state_q == S_REC);
  assign ctl.full    = full;
  assign ctl.v_ge_ve = (smp_q >= evict_q);
  assign ctl.smp     = smp_q;
  assign ctl.evict   = evict_q;

  // Sorted chain of cells, smallest at position 0
  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    link_t prev_l, next_l;

    if (k == 0) begin : g_head
      assign prev_l.val = '0;
      assign prev_l.gt  = 1'b0;
    end else begin : g_body_prev
      assign prev_l = link[k-1];
    end

    if (k == WINDOW - 1) begin : g_tail
      assign next_l.val = '0;
      assign next_l.gt  = 1'b1;
    end else begin : g_body_next
      assign next_l = link[k+1];
    end

    swqd_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .valid_i (held_q > CNTW'(k)),
      .prev_i  (prev_l),
      .next_i  (next_l),
      .link_o  (link[k])
    );

    assign cell_vals[k] = link[k].val;
  end

  swqd_select #(
    .WINDOW (WINDOW)
  ) u_select (
    .clk_i   (clk_i),
    .load_i  (state_q == S_GATHER),
    .rank_i  (rank_q),
    .cells_i (cell_vals),
    .pick_o  (tree_pick)
  );

  // Register read-back
  always_comb begin
    case (paddr[CFG_AW-1:REG_LSB])
      REG_ALPHA: prdata = CFG_DW'(alpha_q);
      REG_MIN:   prdata = min_q;
      REG_MAX:   prdata = max_q;
      default:   prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_obs_q, out_delay_q};

endmodule

>>> design/swqd_checker.sv
// Port-level checks for the sliding-window quantile delay block, with its bind.
module swqd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [swqd_pkg::OUT_W-1:0]  m_axis_tdata
);
  import swqd_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // A query keeps the input side busy through its four work steps
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_QUERY)
    |=> !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready ##1 !s_axis_tready)
    else $error("query pipeline released the input early");

  // A record occupies one chain update and then frees the input
  a_record_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RECORD)
    |=> !s_axis_tready ##1 s_axis_tready)
    else $error("record did not complete in two cycles");

  // A new result only appears at the end of a query
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a query in work");

endmodule

bind sliding_window_quantile_delay swqd_checker u_swqd_checker (.*);

>>> tb/sliding_window_quantile_delay_tb.sv
// Self-checking testbench for the sliding-window quantile delay block.
module sliding_window_quantile_delay_tb;
  import swqd_pkg::*;

  localparam int unsigned WINDOW        = 32;
  localparam int unsigned PERCENT_SCALE = 100;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned PRINT_LIMIT   = 40;
  // Index past the register map; writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [DATA_W-1:0]    ALL_ONES     = {DATA_W{1'b1}};

  typedef struct {
    logic [DATA_W-1:0]  delay;
    logic [TOTAL_W-1:0] observations;
  } delay_report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;   // [63:0] latency
  logic                 s_axis_tuser;   // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;   // [63:0] delay, [95:64] observations
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [CFG_DW-1:0]    pwdata;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  // Shadow copy of the block's window, counts and registers
  logic [DATA_W-1:0]    window_ring [WINDOW];
  int unsigned          ring_slot;
  int unsigned          held_n;
  logic [TOTAL_W-1:0]   obs_total;
  logic [ALPHA_W-1:0]   cfg_alpha;
  logic [DATA_W-1:0]    cfg_min;
  logic [DATA_W-1:0]    cfg_max;

  delay_report_t        expected_reports [$];
  int unsigned          mismatch_count;
  int unsigned          cycle_count;
  bit                   src_idle_on;
  bit                   sink_idle_on;
  bit                   sink_hold_req;
  int unsigned          sink_stall_left;

  sliding_window_quantile_delay #(
    .WINDOW (WINDOW)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock: period 8
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Drive the result ready: random short stalls, or one long hold on request
  always @(posedge clk_i) begin
    if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      sink_stall_left = HOLD_CYCLES;
    end else if (sink_stall_left == 0 && sink_idle_on && $urandom_range(0, 5) == 0) begin
      sink_stall_left = $urandom_range(1, 9);
    end
    if (sink_stall_left != 0) begin
      sink_stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s got 0x%016h want 0x%016h",
               cycle_count, what, got, want);
    end
    mismatch_count++;
  endtask

  // Compare each result word with the oldest expected report
  always @(posedge clk_i) begin
    delay_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected word, delay", m_axis_tdata[DATA_W-1:0], '0);
      end else begin
        want = expected_reports.pop_front();
        if (m_axis_tdata[DATA_W-1:0] !== want.delay) begin
          report_mismatch("delay", m_axis_tdata[DATA_W-1:0], want.delay);
        end
        if (m_axis_tdata[OUT_W-1:DATA_W] !== want.observations) begin
          report_mismatch("observations", {32'd0, m_axis_tdata[OUT_W-1:DATA_W]},
                          {32'd0, want.observations});
        end
      end
    end
  end

  // Quantile of the held samples, clamped up to min then down to max; below ten samples, max
  function automatic logic [DATA_W-1:0] conformal_delay();
    logic [DATA_W-1:0] sorted [WINDOW];
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] pick;
    int unsigned       n;
    int unsigned       alpha;
    int unsigned       num;
    int unsigned       ceiled;
    int unsigned       rank;
    int                j;
    n = held_n;
    if (n < MIN_SAMPLES) begin
      return cfg_max;
    end
    for (int i = 0; i < n; i++) begin
      sorted[i] = window_ring[i];
    end
    for (int i = 1; i < n; i++) begin
      v = sorted[i];
      j = i;
      while (j > 0 && sorted[j-1] > v) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = v;
    end
    alpha = (cfg_alpha >= ALPHA_LOW && cfg_alpha <= ALPHA_HIGH) ? cfg_alpha : ALPHA_DEFAULT;
    num = (n + 1) * (PERCENT_SCALE - alpha);
    ceiled = (num + ROUND_UP) / PERCENT_SCALE;
    rank = (ceiled > 0) ? ceiled - 1 : 0;
    if (rank > n - 1) begin
      rank = n - 1;
    end
    pick = sorted[rank];
    if (pick < cfg_min) begin
      pick = cfg_min;
    end
    if (pick > cfg_max) begin
      pick = cfg_max;
    end
    return pick;
  endfunction

  // Advance the shadow state for one accepted word
  task automatic absorb_item(input logic op, input logic [DATA_W-1:0] lat);
    delay_report_t rep;
    if (op == OP_RECORD) begin
      window_ring[ring_slot] = lat;
      ring_slot = (ring_slot + 1) % WINDOW;
      if (held_n < WINDOW) begin
        held_n++;
      end
      if (obs_total != {TOTAL_W{1'b1}}) begin
        obs_total++;
      end
    end else begin
      rep.delay = conformal_delay();
      rep.observations = obs_total;
      expected_reports.push_back(rep);
    end
  endtask

  // Offer one word, with an occasional idle burst first
  task automatic send_item(input logic op, input logic [DATA_W-1:0] lat);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= lat;
    do @(posedge clk_i); while (!s_axis_tready);
    absorb_item(op, lat);
  endtask

  // Stop sending and wait for every expected word, then let records settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup then access phase; the register takes the value on the access edge
  task automatic write_register(input logic [REG_IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ALPHA: cfg_alpha = value[ALPHA_W-1:0];
      REG_MIN:   cfg_min = value;
      REG_MAX:   cfg_max = value;
      default:   ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] random_latency();
    case ($urandom_range(0, 7))
      0, 1:    return {$urandom, $urandom};
      2:       return '0;
      3:       return ALL_ONES;
      default: return DATA_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] random_clamp();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return {$urandom, $urandom};
      default: return DATA_W'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] random_alpha();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return ALPHA_LOW;
      2:       return ALPHA_HIGH;
      3:       return 8'd100;
      4:       return 8'd255;
      default: return ALPHA_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_item(input int unsigned query_pct);
    if ($urandom_range(1, 100) <= query_pct) begin
      send_item(OP_QUERY, {$urandom, $urandom});
    end else begin
      send_item(OP_RECORD, random_latency());
    end
  endtask

  // Below ten samples the answer is max; the tenth sample enables the quantile
  task automatic test_few_samples();
    send_item(OP_QUERY, '0);
    send_item(OP_RECORD, '0);
    send_item(OP_RECORD, ALL_ONES);
    send_item(OP_RECORD, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_RECORD, 64'h5555_5555_5555_5555);
    for (int i = 0; i < 5; i++) begin
      send_item(OP_RECORD, 64'd7 + i);
    end
    send_item(OP_QUERY, ALL_ONES);
    send_item(OP_RECORD, 64'd7);
    send_item(OP_QUERY, '0);
    send_item(OP_RECORD, 64'd300);
  endtask

  // Alpha at and beyond the edges of its valid range
  task automatic test_alpha_range();
    logic [ALPHA_W-1:0] alphas [5];
    alphas = '{8'd0, ALPHA_LOW, ALPHA_HIGH, 8'd100, 8'd255};
    foreach (alphas[i]) begin
      drain();
      write_register(REG_ALPHA, DATA_W'(alphas[i]));
      send_item(OP_QUERY, '0);
    end
  endtask

  // Crossed and narrow clamps, and a write to an unmapped register
  task automatic test_clamps();
    drain();
    write_register(REG_ALPHA, 64'd50);
    write_register(REG_MIN, ALL_ONES);
    write_register(REG_MAX, '0);
    send_item(OP_QUERY, '0);
    drain();
    write_register(REG_MIN, 64'd8);
    write_register(REG_MAX, 64'd9);
    send_item(OP_QUERY, '0);
    drain();
    write_register(REG_UNMAPPED, '0);
    send_item(OP_QUERY, '0);
  endtask

  // Phases of random words, each under a fresh register setting
  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      drain();
      write_register(REG_ALPHA, DATA_W'(random_alpha()));
      write_register(REG_MIN, random_clamp());
      write_register(REG_MAX, random_clamp());
      if ($urandom_range(0, 3) == 0) begin
        write_register(REG_UNMAPPED, {$urandom, $urandom});
      end
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < per_phase; i++) begin
        send_random_item(30);
      end
    end
  endtask

  // Hold the result side off while queries keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    write_register(REG_ALPHA, 64'd10);
    write_register(REG_MIN, '0);
    write_register(REG_MAX, ALL_ONES);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    sink_hold_req = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_random_item(50);
    end
  endtask

  // Back-to-back words with no idling on either side
  task automatic test_full_rate();
    drain();
    write_register(REG_ALPHA, DATA_W'(random_alpha()));
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int i = 0; i < 40; i++) begin
      send_random_item(35);
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tuser   <= OP_RECORD;
    s_axis_tdata   <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sink_hold_req   = 1'b0;
    sink_stall_left = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    ring_slot       = 0;
    held_n          = 0;
    obs_total       = '0;
    cfg_alpha       = ALPHA_DEFAULT;
    cfg_min         = '0;
    cfg_max         = ALL_ONES;
    foreach (window_ring[i]) begin
      window_ring[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_few_samples();
    test_alpha_range();
    test_clamps();
    test_random_phases(10, 48);
    test_backpressure();
    test_full_rate();
    drain();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
design/swqd_pkg.sv
design/swqd_cell.sv
design/swqd_select.sv
design/sliding_window_quantile_delay.sv
design/swqd_checker.sv
tb/sliding_window_quantile_delay_tb.sv
